>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define CHM_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("chm assertion failed");

// same, but also checked while reset is held
`define CHM_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("chm assertion failed");

`endif

>>> rtl/chm_pkg.sv
// package: constants, codes and beat types of the chained hash multimap
`default_nettype none
package chm_pkg;

    localparam int BUCKETS         = 128;
    localparam int NODES           = 1024;
    localparam int BKT_W           = $clog2(BUCKETS);
    localparam int NODE_W          = $clog2(NODES);
    localparam int LINK_W          = NODE_W + 1;
    localparam int CFG_W           = 8;
    localparam int KEY_W           = 32;
    localparam int CNT_W           = 11;
    localparam int DIV_CNT_W       = $clog2(KEY_W);
    localparam logic [CFG_W-1:0]   DEFAULT_BUCKETS = CFG_W'(100);
    localparam logic [CFG_W-1:0]   MAX_BUCKETS     = CFG_W'(BUCKETS);
    localparam logic [LINK_W-1:0]  NULL_LINK       = LINK_W'(NODES);
    localparam logic [CNT_W-1:0]   COUNT_MAX       = '1;

    typedef enum logic [2:0] {
        REQ_ADD      = 3'd0,
        REQ_REMOVE   = 3'd1,
        REQ_HAS_KEY  = 3'd2,
        REQ_HAS_PAIR = 3'd3,
        REQ_COUNT    = 3'd4,
        REQ_GET      = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_DUP  = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_HEAD_RD,
        S_HEAD_TAKE,
        S_CHECK,
        S_NODE_TAKE,
        S_ADD_NODE,
        S_ADD_LINK,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [2:0]        req_type;
        logic signed [31:0] key;
        logic signed [31:0] data;
    } chm_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value;
        logic [CNT_W-1:0]   match_count;
    } chm_out_t;

endpackage
`default_nettype wire

>>> rtl/chm_ram.sv
// generic single write, single registered read port ram
`default_nettype none
module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

>>> rtl/chained_hash_multimap.sv
// Chained hash multimap: one request beat in, one result beat out.
// Input channel s_valid/s_ready/s_data carries req_type, key and data; the
// result channel m_valid/m_ready/m_data carries status, value, match_count.
// cfg_wr_en/cfg_wr_data write the bucket count (0 taken as 1, above 128 as
// 128) and empty the table; write only while no request is in flight.
// One request at a time: s_ready is high only in the idle state.
// Steps per request: the bucket index (one remainder bit a cycle in the
// subtract/compare unit), the bucket head fetch (read, then take), a
// node memory read then compare for each chain node visited, the
// end-of-chain check, for an add that appends a node write and a link
// write, and the load of the result register. The next beat is taken
// once the sequencer is back in the idle state.
// The result register parts the two sides: a finished result waits there
// while the receiver stalls, and the next request is accepted meanwhile,
// but its own result is held back until the register is free.
// Reset (aresetn low, synchronous) sets the bucket count to 100, marks all
// buckets empty (per-bucket valid flags) and resets the slot counter; node
// memory needs no clearing pass.
`default_nettype none
module chained_hash_multimap import chm_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire chm_in_t          s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output chm_out_t              m_data
);

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     bcount_reg, bcount_next;
    logic [BUCKETS-1:0]   hvalid_reg, hvalid_next;
    logic [LINK_W-1:0]    free_reg, free_next;
    chm_in_t              req_reg, req_next;
    logic [CFG_W-1:0]     rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] dcnt_reg, dcnt_next;
    logic [LINK_W-1:0]    cur_reg, cur_next;
    logic [LINK_W-1:0]    prev_reg, prev_next;
    logic [1:0]           status_reg, status_next;
    logic [31:0]          value_reg, value_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 mvalid_reg, mvalid_next;
    chm_out_t             mdata_reg, mdata_next;

    logic [BKT_W-1:0]     bucket;
    logic [LINK_W-1:0]    head_rd;
    logic                 head_we;
    logic [LINK_W-1:0]    head_wd;
    logic [63:0]          kv_rd;
    logic                 kv_we;
    logic [LINK_W-1:0]    link_rd;
    logic                 link_we;
    logic [NODE_W-1:0]    link_wa;
    logic [LINK_W-1:0]    link_wd;
    logic [CFG_W-1:0]     shifted;
    logic                 key_hit;
    logic                 pair_hit;

    assign bucket   = rem_reg[BKT_W-1:0];
    assign key_hit  = (kv_rd[63:32] == req_reg.key);
    assign pair_hit = key_hit && (kv_rd[31:0] == req_reg.data);
    assign shifted  = {rem_reg[CFG_W-2:0], req_reg.key[dcnt_reg]};

    // bucket heads, node key/data pairs and node links
    chm_ram #(.WIDTH(LINK_W), .DEPTH(BUCKETS)) u_heads (
        .aclk(aclk), .wr_en(head_we), .wr_addr(bucket), .wr_data(head_wd),
        .rd_addr(bucket), .rd_data(head_rd)
    );

    chm_ram #(.WIDTH(64), .DEPTH(NODES)) u_pairs (
        .aclk(aclk), .wr_en(kv_we), .wr_addr(free_reg[NODE_W-1:0]),
        .wr_data({req_reg.key, req_reg.data}),
        .rd_addr(cur_reg[NODE_W-1:0]), .rd_data(kv_rd)
    );

    chm_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) u_links (
        .aclk(aclk), .wr_en(link_we), .wr_addr(link_wa), .wr_data(link_wd),
        .rd_addr(cur_reg[NODE_W-1:0]), .rd_data(link_rd)
    );

    // state and data registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            bcount_reg <= DEFAULT_BUCKETS;
            hvalid_reg <= '0;
            free_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            bcount_reg <= bcount_next;
            hvalid_reg <= hvalid_next;
            free_reg   <= free_next;
            mvalid_reg <= mvalid_next;
        end
        req_reg    <= req_next;
        rem_reg    <= rem_next;
        dcnt_reg   <= dcnt_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        status_reg <= status_next;
        value_reg  <= value_next;
        count_reg  <= count_next;
        mdata_reg  <= mdata_next;
    end

    // sequencer: divide, fetch head, walk chain, update, report
    always_comb begin
        state_next  = state_reg;
        bcount_next = bcount_reg;
        hvalid_next = hvalid_reg;
        free_next   = free_reg;
        req_next    = req_reg;
        rem_next    = rem_reg;
        dcnt_next   = dcnt_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        status_next = status_reg;
        value_next  = value_reg;
        count_next  = count_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        head_we     = 1'b0;
        head_wd     = link_rd;
        kv_we       = 1'b0;
        link_we     = 1'b0;
        link_wa     = prev_reg[NODE_W-1:0];
        link_wd     = link_rd;
        s_ready     = (state_reg == S_IDLE);

        // result register drains
        if (mvalid_reg && m_ready) begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next    = s_data;
                    rem_next    = '0;
                    dcnt_next   = DIV_CNT_W'(KEY_W - 1);
                    status_next = ST_MISS;
                    value_next  = '0;
                    count_next  = '0;
                    prev_next   = NULL_LINK;
                    state_next  = S_DIV;
                end
            end
            S_DIV: begin
                // one restoring remainder step per cycle
                if (shifted >= bcount_reg) begin
                    rem_next = shifted - bcount_reg;
                end else begin
                    rem_next = shifted;
                end
                dcnt_next = dcnt_reg - 1'b1;
                if (dcnt_reg == '0) begin
                    state_next = (req_reg.req_type > REQ_GET) ? S_FINISH : S_HEAD_RD;
                end
            end
            S_HEAD_RD: begin
                state_next = S_HEAD_TAKE;
            end
            S_HEAD_TAKE: begin
                cur_next   = hvalid_reg[bucket] ? head_rd : NULL_LINK;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (cur_reg[NODE_W]) begin
                    // end of chain
                    state_next = S_FINISH;
                    if (req_reg.req_type == REQ_ADD) begin
                        if (free_reg[NODE_W]) begin
                            status_next = ST_FULL;
                        end else begin
                            state_next = S_ADD_NODE;
                        end
                    end else if (req_reg.req_type == REQ_COUNT) begin
                        status_next = (count_reg != '0) ? ST_OK : ST_MISS;
                    end
                end else begin
                    state_next = S_NODE_TAKE;
                end
            end
            S_NODE_TAKE: begin
                prev_next  = cur_reg;
                cur_next   = link_rd;
                state_next = S_CHECK;
                case (req_reg.req_type)
                    REQ_ADD: begin
                        if (pair_hit) begin
                            status_next = ST_DUP;
                            state_next  = S_FINISH;
                        end
                    end
                    REQ_REMOVE: begin
                        if (pair_hit) begin
                            if (prev_reg[NODE_W]) begin
                                head_we             = 1'b1;
                                hvalid_next[bucket] = 1'b1;
                            end else begin
                                link_we = 1'b1;
                            end
                            status_next = ST_OK;
                            state_next  = S_FINISH;
                        end
                    end
                    REQ_HAS_KEY: begin
                        if (key_hit) begin
                            status_next = ST_OK;
                            state_next  = S_FINISH;
                        end
                    end
                    REQ_HAS_PAIR: begin
                        if (pair_hit) begin
                            status_next = ST_OK;
                            state_next  = S_FINISH;
                        end
                    end
                    REQ_COUNT: begin
                        if (key_hit && count_reg != COUNT_MAX) begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    REQ_GET: begin
                        if (key_hit) begin
                            status_next = ST_OK;
                            value_next  = kv_rd[31:0];
                            state_next  = S_FINISH;
                        end
                    end
                    default: begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_ADD_NODE: begin
                // new node at the free slot, null link
                kv_we      = 1'b1;
                link_we    = 1'b1;
                link_wa    = free_reg[NODE_W-1:0];
                link_wd    = NULL_LINK;
                state_next = S_ADD_LINK;
            end
            S_ADD_LINK: begin
                // hook the node onto the chain tail
                if (prev_reg[NODE_W]) begin
                    head_we             = 1'b1;
                    head_wd             = free_reg;
                    hvalid_next[bucket] = 1'b1;
                end else begin
                    link_we = 1'b1;
                    link_wd = free_reg;
                end
                free_next   = free_reg + 1'b1;
                status_next = ST_OK;
                state_next  = S_FINISH;
            end
            S_FINISH: begin
                if (!mvalid_reg || m_ready) begin
                    mvalid_next            = 1'b1;
                    mdata_next.status      = status_reg;
                    mdata_next.value       = value_reg;
                    mdata_next.match_count = count_reg;
                    state_next             = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // bucket count write empties the table
        if (cfg_wr_en) begin
            if (cfg_wr_data == '0) begin
                bcount_next = CFG_W'(1);
            end else if (cfg_wr_data > MAX_BUCKETS) begin
                bcount_next = MAX_BUCKETS;
            end else begin
                bcount_next = cfg_wr_data;
            end
            hvalid_next = '0;
            free_next   = '0;
        end
    end

    assign m_valid = mvalid_reg;
    assign m_data  = mdata_reg;

endmodule
`default_nettype wire

>>> rtl/chm_checker.sv
// port-level checks for the chained hash multimap, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module chm_checker import chm_pkg::*; (
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_valid,
    input wire logic     s_ready,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire chm_out_t m_data
);

    // a stalled result beat stays
    `CHM_ASSERT(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid)
    // one request at a time: busy after an input beat
    `CHM_ASSERT(a_busy, aclk, aresetn, s_valid && s_ready |=> !s_ready)
    // a nonzero count only comes with success
    `CHM_ASSERT(a_cnt, aclk, aresetn, m_valid && m_data.match_count != '0 |-> m_data.status == ST_OK)
    // a nonzero value only comes with success
    `CHM_ASSERT(a_val, aclk, aresetn, m_valid && m_data.value != '0 |-> m_data.status == ST_OK)
    // no result beat the cycle after reset
    `CHM_ASSERT_ALWAYS(a_rst, aclk, !aresetn |=> !m_valid)

endmodule

bind chained_hash_multimap chm_checker u_chm_checker (.*);
`default_nettype wire
